// ----- rtl/sprite_blit_tint_clip_assert.svh -----
// ----------------------------------------------------------------------------
// Sprite blitter assertion macros
// Shorthand for the concurrent checks of the sprite blitter checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_BLIT_TINT_CLIP_ASSERT_SVH
`define SPRITE_BLIT_TINT_CLIP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- rtl/sbtc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite blitter package
// Shared sizes, register indexes and the configuration record.
// ----------------------------------------------------------------------------
package sbtc_pkg;

    // Frame and surface limits.
    localparam int FRAME_DIM   = 256;
    localparam int SURFACE_DIM = 4096;

    // Comparison widths: frame coordinates, clip bounds, signed positions.
    localparam int FRAME_CMP_W = 13;
    localparam int CLIP_W      = 17;
    localparam int POS_W       = CLIP_W + 1;

    // Tint word value that turns tinting off.
    localparam logic [31:0] TINT_OFF = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X       = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y       = 3'd1;
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TINT_COLOR     = 3'd4;
    localparam logic [2:0] REG_DRAW_ALPHA     = 3'd5;
    localparam logic [2:0] REG_SHADOW_ALPHA   = 3'd6;
    localparam logic [2:0] REG_SHADOW_OFFSETS = 3'd7;

    // Current register contents, handed from the register file to the datapath.
    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [12:0] surface_width;
        logic [12:0] surface_height;
        logic [31:0] tint_color;
        logic [7:0]  draw_alpha;
        logic [7:0]  shadow_alpha;
        logic [15:0] shadow_offsets;
    } cfg_t;

endpackage

// ----- rtl/sbtc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Sprite blitter configuration registers
// Holds the eight write-only control registers.
// ----------------------------------------------------------------------------
module sbtc_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    output sbtc_pkg::cfg_t cfg
);
    import sbtc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and replace the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ORIGIN_X:       cfg_next.origin_x       = cfg_wdata[15:0];
                REG_ORIGIN_Y:       cfg_next.origin_y       = cfg_wdata[15:0];
                REG_SURFACE_WIDTH:  cfg_next.surface_width  = cfg_wdata[12:0];
                REG_SURFACE_HEIGHT: cfg_next.surface_height = cfg_wdata[12:0];
                REG_TINT_COLOR:     cfg_next.tint_color     = cfg_wdata;
                REG_DRAW_ALPHA:     cfg_next.draw_alpha     = cfg_wdata[7:0];
                REG_SHADOW_ALPHA:   cfg_next.shadow_alpha   = cfg_wdata[7:0];
                REG_SHADOW_OFFSETS: cfg_next.shadow_offsets = cfg_wdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x       <= 16'd0;
            cfg_reg.origin_y       <= 16'd0;
            cfg_reg.surface_width  <= 13'd0;
            cfg_reg.surface_height <= 13'd0;
            cfg_reg.tint_color     <= TINT_OFF;
            cfg_reg.draw_alpha     <= 8'd128;
            cfg_reg.shadow_alpha   <= 8'd64;
            cfg_reg.shadow_offsets <= 16'h0202;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/sbtc_tint.sv -----
// ----------------------------------------------------------------------------
// Sprite blitter tint unit
// Scales each RGB332 channel by its tint byte over 255, truncating.
// ----------------------------------------------------------------------------
module sbtc_tint
(
    input  logic [31:0] tint_color,
    input  logic [7:0]  pixel_value,
    output logic [7:0]  tinted_value
);
    import sbtc_pkg::*;

    // Floor of x / 255 for x below 2040, by the add-and-shift identity.
    function automatic logic [2:0] div255(input logic [10:0] x);
        logic [11:0] sum;
        begin
            sum    = {1'b0, x} + {9'b0, x[10:8]} + 12'd1;
            div255 = sum[10:8];
        end
    endfunction

    logic [10:0] prod_r;
    logic [10:0] prod_g;
    logic [10:0] prod_b;
    logic [2:0]  chan_r;
    logic [2:0]  chan_g;
    logic [2:0]  chan_b;

    // One small multiply per channel, carried out at the full product width.
    assign prod_r = {8'b0, pixel_value[7:5]} * {3'b0, tint_color[23:16]};
    assign prod_g = {8'b0, pixel_value[4:2]} * {3'b0, tint_color[15:8]};
    assign prod_b = {9'b0, pixel_value[1:0]} * {3'b0, tint_color[7:0]};

    assign chan_r = div255(prod_r);
    assign chan_g = div255(prod_g);
    assign chan_b = div255(prod_b);

    // The blue result never exceeds three, so two bits carry it.
    assign tinted_value = (tint_color == TINT_OFF) ? pixel_value
                                                   : {chan_r, chan_g, chan_b[1:0]};

endmodule

// ----- rtl/sbtc_place.sv -----
// ----------------------------------------------------------------------------
// Sprite blitter placement and clipping
// Offsets the frame coordinates to the surface and tests the clip window.
// ----------------------------------------------------------------------------
module sbtc_place
(
    input  sbtc_pkg::cfg_t cfg,
    input  logic           req_type,
    input  logic [7:0]     pixel_x,
    input  logic [7:0]     pixel_y,
    output logic           visible,
    output logic [11:0]    write_x,
    output logic [11:0]    write_y
);
    import sbtc_pkg::*;

    logic [POS_W-1:0]  org_x_ext;
    logic [POS_W-1:0]  org_y_ext;
    logic [POS_W-1:0]  off_x_ext;
    logic [POS_W-1:0]  off_y_ext;
    logic [POS_W-1:0]  dest_x;
    logic [POS_W-1:0]  dest_y;
    logic [CLIP_W-1:0] lim_w;
    logic [CLIP_W-1:0] lim_h;
    logic              in_frame;
    logic              in_x;
    logic              in_y;

    // Sign-extend the origin and, on the shadow pass, the shadow offsets.
    assign org_x_ext = {{(POS_W-16){cfg.origin_x[15]}}, cfg.origin_x};
    assign org_y_ext = {{(POS_W-16){cfg.origin_y[15]}}, cfg.origin_y};
    assign off_x_ext = req_type ? {{(POS_W-8){cfg.shadow_offsets[7]}},
                                   cfg.shadow_offsets[7:0]}
                                : '0;
    assign off_y_ext = req_type ? {{(POS_W-8){cfg.shadow_offsets[15]}},
                                   cfg.shadow_offsets[15:8]}
                                : '0;

    assign dest_x = org_x_ext + {{(POS_W-8){1'b0}}, pixel_x} + off_x_ext;
    assign dest_y = org_y_ext + {{(POS_W-8){1'b0}}, pixel_y} + off_y_ext;

    // Clip bounds are the programmed size capped at the largest surface.
    assign lim_w = ({{(CLIP_W-13){1'b0}}, cfg.surface_width} < CLIP_W'(SURFACE_DIM))
                 ? {{(CLIP_W-13){1'b0}}, cfg.surface_width} : CLIP_W'(SURFACE_DIM);
    assign lim_h = ({{(CLIP_W-13){1'b0}}, cfg.surface_height} < CLIP_W'(SURFACE_DIM))
                 ? {{(CLIP_W-13){1'b0}}, cfg.surface_height} : CLIP_W'(SURFACE_DIM);

    // Frame bounds check on the source coordinates.
    assign in_frame = ({{(FRAME_CMP_W-8){1'b0}}, pixel_x} < FRAME_CMP_W'(FRAME_DIM))
                   && ({{(FRAME_CMP_W-8){1'b0}}, pixel_y} < FRAME_CMP_W'(FRAME_DIM));

    // A position is on the surface when it is non-negative and below the bound.
    assign in_x = !dest_x[POS_W-1] && (dest_x[CLIP_W-1:0] < lim_w);
    assign in_y = !dest_y[POS_W-1] && (dest_y[CLIP_W-1:0] < lim_h);

    assign visible = in_frame && in_x && in_y;
    assign write_x = dest_x[11:0];
    assign write_y = dest_y[11:0];

endmodule

// ----- rtl/sprite_blit_tint_clip.sv -----
// ----------------------------------------------------------------------------
// Sprite blitter with tint, color key and clipping
// Turns a stream of sprite pixels into a stream of surface pixel writes.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the write stream is not stalled and
// answers with zero or one write: the pixel lands in an input register, tint,
// color key, placement and clipping are evaluated in one pass of logic, and a
// visible pixel is caught in the result register. The block holds no other
// per-pixel state and needs no warm-up after reset. Transparent, off-frame
// and off-surface pixels, and all pixels while the draw alpha is zero,
// produce no transaction on the output. Registers are to be written only
// while no pixel is in flight.
module sprite_blit_tint_clip
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Pixel input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_x[7:0], pixel_y[15:8], pixel_value[23:16]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    // Pixel write stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // write_x[11:0], write_y[23:12], write_alpha[31:24]
    output logic [0:0]  m_axis_tuser    // write_white[0]
);
    import sbtc_pkg::*;

    cfg_t        cfg;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_type_reg;
    logic [7:0]  in_x_reg;
    logic [7:0]  in_y_reg;
    logic [7:0]  in_value_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    logic        out_white_reg;
    logic [7:0]  out_alpha_reg;

    logic [7:0]  tinted_value;
    logic        visible;
    logic [11:0] write_x;
    logic [11:0] write_y;
    logic        hit;
    logic        out_free;
    logic        in_take;

    sbtc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sbtc_tint u_tint
    (
        .tint_color   (cfg.tint_color),
        .pixel_value  (in_value_reg),
        .tinted_value (tinted_value)
    );

    sbtc_place u_place
    (
        .cfg      (cfg),
        .req_type (in_type_reg),
        .pixel_x  (in_x_reg),
        .pixel_y  (in_y_reg),
        .visible  (visible),
        .write_x  (write_x),
        .write_y  (write_y)
    );

    // Flow control: the result register frees up when empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // A write is emitted for a visible, opaque pixel while drawing is enabled.
    assign hit = in_valid_reg && (cfg.draw_alpha != 8'd0)
              && (tinted_value != 8'd0) && visible;

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = out_free ? hit : out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register captures each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg  <= s_axis_tuser[0];
            in_x_reg     <= s_axis_tdata[7:0];
            in_y_reg     <= s_axis_tdata[15:8];
            in_value_reg <= s_axis_tdata[23:16];
        end
    end

    // Result register captures each produced write.
    always_ff @(posedge clk)
    begin
        if (out_free && hit)
        begin
            out_x_reg     <= write_x;
            out_y_reg     <= write_y;
            out_white_reg <= !in_type_reg;
            out_alpha_reg <= in_type_reg ? cfg.shadow_alpha : cfg.draw_alpha;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_alpha_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_white_reg;

endmodule

// ----- rtl/sbtc_checker.sv -----
// ----------------------------------------------------------------------------
// Sprite blitter port checker
// Watches the top-level streams for flow and content errors.
// ----------------------------------------------------------------------------
`include "sprite_blit_tint_clip_assert.svh"

module sbtc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled write transaction keeps its contents.
    `SBTC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // With the output empty the input side always has room.
    `SBTC_ASSERT_NOW(a_in_room, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // Main-pass writes only happen while the draw alpha is nonzero.
    `SBTC_ASSERT_NOW(a_white_alpha, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:24] != 8'd0)

    // A fresh write stems from an input transaction caught in the input register, then in the result register.
    `SBTC_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind sprite_blit_tint_clip sbtc_checker u_sbtc_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite blitter testbench
// Streams sprite pixels into the blitter under random register settings and
// random stalls on both sides. Each pixel transaction is scored against a
// local model of tint, color key, placement and clipping. Every write
// transaction is compared field by field with the oldest predicted write.
// ----------------------------------------------------------------------------
module tb_top;
    import sbtc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_IDLE     = 5;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTED  = 40;

    // One source pixel and one destination write.
    typedef struct packed {
        logic       shadow;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] value;
    } sprite_pix_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic        white;
        logic [7:0]  alpha;
    } pix_write_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_addr      = '0;
    logic [31:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // pixel_x[7:0], pixel_y[15:8], pixel_value[23:16]
    logic [0:0]  s_axis_tuser  = '0;   // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // write_x[11:0], write_y[23:12], write_alpha[31:24]
    logic [0:0]  m_axis_tuser;         // write_white[0]

    // Register copy used for prediction, pixel and write queues, counters.
    cfg_t        regs_model;
    sprite_pix_t pix_pending_q[$];
    pix_write_t  wr_expect_q[$];
    int          pix_pushed    = 0;
    int          pix_accepted  = 0;
    int          mismatch_cnt  = 0;
    int          cycle_cnt     = 0;
    int          gap_left      = 0;
    int          stall_left    = 0;
    bit          no_idle       = 1'b0;

    sprite_blit_tint_clip DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Computes the write a pixel causes under the current registers.
    function automatic bit predict_write(input logic shadow, input logic [7:0] px,
                                         input logic [7:0] py, input logic [7:0] pv,
                                         output pix_write_t w);
        int         r;
        int         g;
        int         b;
        int         dx;
        int         dy;
        int         lim_w;
        int         lim_h;
        logic [7:0] v;
        w = '0;
        if (regs_model.draw_alpha == 8'd0)
            return 1'b0;
        if (int'(px) >= FRAME_DIM || int'(py) >= FRAME_DIM)
            return 1'b0;
        v = pv;
        // Tint scales each channel by its byte and truncates the divide by 255.
        if (regs_model.tint_color != TINT_OFF)
        begin
            r = (int'(pv[7:5]) * int'(regs_model.tint_color[23:16])) / 255;
            g = (int'(pv[4:2]) * int'(regs_model.tint_color[15:8])) / 255;
            b = (int'(pv[1:0]) * int'(regs_model.tint_color[7:0])) / 255;
            v = {r[2:0], g[2:0], b[1:0]};
        end
        if (v == 8'd0)
            return 1'b0;
        dx = int'($signed(regs_model.origin_x)) + int'(px);
        dy = int'($signed(regs_model.origin_y)) + int'(py);
        if (shadow)
        begin
            dx += int'($signed(regs_model.shadow_offsets[7:0]));
            dy += int'($signed(regs_model.shadow_offsets[15:8]));
        end
        lim_w = (int'(regs_model.surface_width) < SURFACE_DIM) ?
                int'(regs_model.surface_width) : SURFACE_DIM;
        lim_h = (int'(regs_model.surface_height) < SURFACE_DIM) ?
                int'(regs_model.surface_height) : SURFACE_DIM;
        if (dx < 0 || dx >= lim_w || dy < 0 || dy >= lim_h)
            return 1'b0;
        w.x     = dx[11:0];
        w.y     = dy[11:0];
        w.white = ~shadow;
        w.alpha = shadow ? regs_model.shadow_alpha : regs_model.draw_alpha;
        return 1'b1;
    endfunction

    function automatic int draw_idle();
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Random register values, weighted toward positions that land on the surface.
    function automatic logic [15:0] pick_origin();
        int o;
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default:
            begin
                o = int'($urandom_range(0, 4400)) - 300;
                return o[15:0];
            end
        endcase
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4095;
            3:       return 13'd4096;
            4:       return 13'd4097;
            5:       return 13'h1FFF;
            6:       return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(2048, 4096));
        endcase
    endfunction

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    // Fills the unused upper bits of a register write with random junk.
    function automatic logic [31:0] pad_junk(input logic [31:0] val, input int width);
        logic [31:0] mask;
        mask = (32'h1 << width) - 32'h1;
        return ($urandom << width) | (val & mask);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    // Writes one register for a single cycle and updates the local copy.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ORIGIN_X:       regs_model.origin_x       = val[15:0];
            REG_ORIGIN_Y:       regs_model.origin_y       = val[15:0];
            REG_SURFACE_WIDTH:  regs_model.surface_width  = val[12:0];
            REG_SURFACE_HEIGHT: regs_model.surface_height = val[12:0];
            REG_TINT_COLOR:     regs_model.tint_color     = val;
            REG_DRAW_ALPHA:     regs_model.draw_alpha     = val[7:0];
            REG_SHADOW_ALPHA:   regs_model.shadow_alpha   = val[7:0];
            REG_SHADOW_OFFSETS: regs_model.shadow_offsets = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_pix(input logic shadow, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] v);
        sprite_pix_t p;
        p.shadow = shadow;
        p.x      = x;
        p.y      = y;
        p.value  = v;
        pix_pending_q.push_back(p);
        pix_pushed++;
    endtask

    // Waits until every pixel is taken and every write has arrived, then lets
    // the pipeline drain pixels that produce no write.
    task automatic wait_idle();
        while (pix_accepted != pix_pushed || wr_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Pixel driver: scores each accepted transaction, then offers the next
    // pending pixel after a random gap.
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        sprite_pix_t item;
        pix_write_t  w;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_write(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[15:8],
                                  s_axis_tdata[23:16], w))
                    wr_expect_q.push_back(w);
                pix_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pix_pending_q.size() > 0)
                begin
                    item = pix_pending_q.pop_front();
                    s_axis_tdata  <= {item.value, item.y, item.x};
                    s_axis_tuser  <= item.shadow;
                    s_axis_tvalid <= 1'b1;
                    gap_left      <= draw_idle();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Write monitor: checks each write transaction and stalls at random after it.
    always @(posedge clk or negedge rst_n)
    begin : write_monitor
        pix_write_t got;
        pix_write_t want;
        int         k;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got.x     = m_axis_tdata[11:0];
            got.y     = m_axis_tdata[23:12];
            got.alpha = m_axis_tdata[31:24];
            got.white = m_axis_tuser[0];
            if (wr_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected write at (%0d, %0d)", got.x, got.y));
            end
            else
            begin
                want = wr_expect_q.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("write_x %0d, wanted %0d", got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("write_y %0d, wanted %0d", got.y, want.y));
                if (got.white !== want.white)
                    report_mismatch($sformatf("write_white %0b, wanted %0b",
                                              got.white, want.white));
                if (got.alpha !== want.alpha)
                    report_mismatch($sformatf("write_alpha %0d, wanted %0d",
                                              got.alpha, want.alpha));
            end
            k = draw_idle();
            if (k > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= k - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    // Stimulus: directed corners first, then random register phases.
    initial
    begin
        int       n;
        int       n_random;
        bit       first;
        bit       corner;
        logic [31:0] t;
        logic [7:0]  px;
        logic [7:0]  py;

        regs_model.origin_x       = 16'd0;
        regs_model.origin_y       = 16'd0;
        regs_model.surface_width  = 13'd0;
        regs_model.surface_height = 13'd0;
        regs_model.tint_color     = TINT_OFF;
        regs_model.draw_alpha     = 8'd128;
        regs_model.shadow_alpha   = 8'd64;
        regs_model.shadow_offsets = 16'h0202;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset surface is empty, so nothing may be written.
        queue_pix(1'b0, 8'd0, 8'd0, 8'hFF);
        queue_pix(1'b1, 8'd0, 8'd0, 8'hFF);
        wait_idle();

        // Oversized surface clips at the maximum; frame extremes and color key.
        write_reg(REG_SURFACE_WIDTH, 32'h0000_1FFF);
        write_reg(REG_SURFACE_HEIGHT, 32'hFFFF_FFFF);
        queue_pix(1'b0, 8'd0, 8'd0, 8'hFF);
        queue_pix(1'b0, 8'd255, 8'd255, 8'h01);
        queue_pix(1'b0, 8'd10, 8'd10, 8'h00);
        queue_pix(1'b1, 8'd0, 8'd0, 8'hFF);
        queue_pix(1'b1, 8'd255, 8'd255, 8'h80);
        wait_idle();

        // Far surface edge: last column fits, the default shadow falls off,
        // the most negative shadow offsets pull it back.
        write_reg(REG_ORIGIN_X, 32'd3840);
        write_reg(REG_ORIGIN_Y, 32'd3840);
        queue_pix(1'b0, 8'd255, 8'd255, 8'hFF);
        queue_pix(1'b1, 8'd255, 8'd255, 8'hFF);
        wait_idle();
        write_reg(REG_SHADOW_OFFSETS, 32'h0000_8080);
        queue_pix(1'b1, 8'd255, 8'd255, 8'hFF);
        wait_idle();

        // Origin extremes put everything off the surface.
        write_reg(REG_ORIGIN_X, 32'h0000_8000);
        write_reg(REG_ORIGIN_Y, 32'h0000_7FFF);
        queue_pix(1'b0, 8'd0, 8'd0, 8'hFF);
        queue_pix(1'b1, 8'd255, 8'd0, 8'hFF);
        wait_idle();

        // Negative origin and small surface: both clip edges.
        write_reg(REG_ORIGIN_X, 32'hFFFF_FFF6);
        write_reg(REG_ORIGIN_Y, 32'hFFFF_FFF6);
        write_reg(REG_SHADOW_OFFSETS, 32'h0000_7F7F);
        write_reg(REG_SURFACE_WIDTH, 32'd100);
        write_reg(REG_SURFACE_HEIGHT, 32'd100);
        queue_pix(1'b0, 8'd0, 8'd0, 8'hFF);
        queue_pix(1'b0, 8'd10, 8'd10, 8'hFF);
        queue_pix(1'b0, 8'd109, 8'd109, 8'hFF);
        queue_pix(1'b0, 8'd110, 8'd10, 8'hFF);
        queue_pix(1'b1, 8'd0, 8'd0, 8'hFF);
        wait_idle();

        // Tint: all zero makes every pixel transparent, red-only keeps red.
        write_reg(REG_TINT_COLOR, 32'h0000_0000);
        queue_pix(1'b0, 8'd20, 8'd20, 8'hFF);
        wait_idle();
        write_reg(REG_TINT_COLOR, 32'h00FF_0000);
        queue_pix(1'b0, 8'd20, 8'd20, 8'h1F);
        queue_pix(1'b0, 8'd21, 8'd20, 8'hE3);
        wait_idle();
        write_reg(REG_TINT_COLOR, 32'h007F_7F7F);
        queue_pix(1'b0, 8'd22, 8'd20, 8'hFF);
        queue_pix(1'b0, 8'd23, 8'd20, 8'h21);
        wait_idle();
        write_reg(REG_TINT_COLOR, TINT_OFF);

        // Zero draw alpha silences both passes; zero shadow alpha does not.
        write_reg(REG_DRAW_ALPHA, 32'd0);
        queue_pix(1'b0, 8'd30, 8'd30, 8'hFF);
        queue_pix(1'b1, 8'd30, 8'd30, 8'hFF);
        wait_idle();
        write_reg(REG_DRAW_ALPHA, 32'd255);
        write_reg(REG_SHADOW_ALPHA, 32'd0);
        queue_pix(1'b0, 8'd30, 8'd30, 8'hFF);
        queue_pix(1'b1, 8'd30, 8'd30, 8'hFF);
        wait_idle();

        // Random phases: new register settings whenever the block is idle.
        n_random = 0;
        first    = 1'b1;
        while (n_random < RANDOM_ITEMS)
        begin
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            if (first || $urandom_range(0, 1))
                write_reg(REG_ORIGIN_X, pad_junk(pick_origin(), 16));
            if (first || $urandom_range(0, 1))
                write_reg(REG_ORIGIN_Y, pad_junk(pick_origin(), 16));
            if (first || $urandom_range(0, 1))
                write_reg(REG_SURFACE_WIDTH, pad_junk(pick_dim(), 13));
            if (first || $urandom_range(0, 1))
                write_reg(REG_SURFACE_HEIGHT, pad_junk(pick_dim(), 13));
            if (first || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: t = TINT_OFF;
                    3:       t = $urandom;
                    4:       t = $urandom | 32'h00FF_FFFF;
                    default: t = 32'h0;
                endcase
                write_reg(REG_TINT_COLOR, t);
            end
            if (first || $urandom_range(0, 1))
                write_reg(REG_DRAW_ALPHA, pad_junk(pick_alpha(), 8));
            if (first || $urandom_range(0, 1))
                write_reg(REG_SHADOW_ALPHA, pad_junk(pick_alpha(), 8));
            if (first || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 5))
                    0:       t = 32'h8080;
                    1:       t = 32'h7F7F;
                    2:       t = 32'hFF01;
                    default: t = $urandom_range(0, 65535);
                endcase
                write_reg(REG_SHADOW_OFFSETS, pad_junk(t, 16));
            end
            first = 1'b0;

            n = $urandom_range(20, 80);
            repeat (n)
            begin
                corner = ($urandom_range(0, 7) == 0);
                px = corner ? ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom_range(0, 255));
                py = corner ? ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom_range(0, 255));
                queue_pix(1'($urandom_range(0, 1)), px, py,
                          ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            end
            n_random += n;
        end

        wait_idle();
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sprite_blit_tint_clip.f -----
+incdir+rtl
rtl/sbtc_pkg.sv
rtl/sbtc_cfg_regs.sv
rtl/sbtc_tint.sv
rtl/sbtc_place.sv
rtl/sprite_blit_tint_clip.sv
rtl/sbtc_checker.sv
dv/tb_top.sv
